@@ design/sorted_key_value_lookup_unit_macros.svh @@
// Assertion macros used by the lookup unit checker.
`ifndef SORTED_KEY_VALUE_LOOKUP_UNIT_MACROS_SVH
`define SORTED_KEY_VALUE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKVL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lookup unit check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SKVL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lookup unit check failed");

`endif

@@ design/skvl_pkg.sv @@
// Shared types and codes of the sorted key/value lookup unit.
package skvl_pkg;

  localparam int KEY_W = 16;
  localparam int BAL_W = 32;
  localparam int LIMIT_W = 31;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd10000;

  // Action codes carried on the input tuser
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Status codes carried on the output tuser
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FOUND = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // Insert command broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] id;
    logic [BAL_W-1:0] bal;
  } skvl_ins_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             resolved;
    logic             hit;
    logic [KEY_W-1:0] id;
    logic [BAL_W-1:0] bal;
  } skvl_tok_t;

endpackage

@@ design/sorted_key_value_lookup_unit.sv @@
// Latency: clear and load results appear the cycle after the input transfer.
// A lookup result passes along the row of TABLE_DEPTH cells, the search token
// stepping one cell per cycle, then into the output register. One clear or load
// per cycle unless the output stalls; a lookup blocks input until its token exits.
// Reset empties the table (fill count to zero), drops any token and result,
// and sets the credit limit to 10000.
module sorted_key_value_lookup_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cust_id [15:0], balance_in [47:16]
  input  logic [1:0]  s_tuser,   // action [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // balance_out [31:0], over_limit [32], zero [39:33]
  output logic [1:0]  m_tuser,   // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data   // credit_limit [30:0]
);
  import skvl_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]      count;
  logic [LIMIT_W-1:0] credit_limit;
  logic               busy;
  logic               accept;
  logic               full;
  logic [KEY_W-1:0]   in_id;
  logic [BAL_W-1:0]   in_bal;
  skvl_ins_t          ins;
  skvl_tok_t          tok_head;

  logic               cell_gt  [TABLE_DEPTH];
  logic [KEY_W-1:0]   cell_key [TABLE_DEPTH];
  logic [BAL_W-1:0]   cell_bal [TABLE_DEPTH];
  logic               tok_v    [TABLE_DEPTH];
  skvl_tok_t          tok      [TABLE_DEPTH];

  logic               last_v;
  skvl_tok_t          last_tok;
  logic               over;
  logic [BAL_W-1:0]   out_bal;
  logic               out_over;
  logic [1:0]         out_status;

  assign in_id     = s_tdata[KEY_W-1:0];
  assign in_bal    = s_tdata[KEY_W+BAL_W-1:KEY_W];
  assign full      = count == CW'(TABLE_DEPTH);
  assign s_tready  = !busy && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign ins.en  = accept && (s_tuser == ACT_LOAD) && !full;
  assign ins.id  = in_id;
  assign ins.bal = in_bal;

  assign tok_head.resolved = 1'b0;
  assign tok_head.hit      = 1'b0;
  assign tok_head.id       = in_id;
  assign tok_head.bal      = '0;

  // Build the row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      skvl_cell #(.TABLE_DEPTH(TABLE_DEPTH), .IDX(i), .CW(CW)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .count        (count),
        .ins          (ins),
        .prev_gt      (1'b0),
        .prev_key     ({KEY_W{1'b0}}),
        .prev_bal     ({BAL_W{1'b0}}),
        .gt           (cell_gt[i]),
        .key          (cell_key[i]),
        .bal          (cell_bal[i]),
        .tok_in_valid (accept && (s_tuser == ACT_LOOKUP)),
        .tok_in       (tok_head),
        .tok_out_valid(tok_v[i]),
        .tok_out      (tok[i])
      );
    end else begin : g_body
      skvl_cell #(.TABLE_DEPTH(TABLE_DEPTH), .IDX(i), .CW(CW)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .count        (count),
        .ins          (ins),
        .prev_gt      (cell_gt[i-1]),
        .prev_key     (cell_key[i-1]),
        .prev_bal     (cell_bal[i-1]),
        .gt           (cell_gt[i]),
        .key          (cell_key[i]),
        .bal          (cell_bal[i]),
        .tok_in_valid (tok_v[i-1]),
        .tok_in       (tok[i-1]),
        .tok_out_valid(tok_v[i]),
        .tok_out      (tok[i])
      );
    end
  end

  assign last_v   = tok_v[TABLE_DEPTH-1];
  assign last_tok = tok[TABLE_DEPTH-1];
  assign over     = last_tok.hit &&
                    ($signed(last_tok.bal) > $signed({1'b0, credit_limit}));

  // Hold the credit limit
  always_ff @(posedge clk) begin
    if (rst) begin
      credit_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      credit_limit <= cfg_data;
    end
  end

  // Track the fill count and an outstanding lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (accept && (s_tuser == ACT_CLEAR)) begin
        count <= '0;
      end else if (ins.en) begin
        count <= count + CW'(1);
      end
      if (accept && (s_tuser == ACT_LOOKUP)) begin
        busy <= 1'b1;
      end else if (last_v) begin
        busy <= 1'b0;
      end
    end
  end

  // Load the output register from a direct result or a finished token
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((accept && (s_tuser != ACT_LOOKUP)) || last_v) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_v) begin
      out_status <= last_tok.hit ? ST_FOUND : ST_MISS;
      out_bal    <= last_tok.bal;
      out_over   <= over;
    end else if (accept && (s_tuser != ACT_LOOKUP)) begin
      out_status <= (s_tuser == ACT_LOAD && full) ? ST_FULL : ST_DONE;
      out_bal    <= '0;
      out_over   <= 1'b0;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {7'b0, out_over, out_bal};

endmodule

@@ design/skvl_cell.sv @@
// One table cell: holds an entry, shifts on insert, resolves a passing search token.
module skvl_cell #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX = 0,
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CW-1:0]            count,
  input  skvl_pkg::skvl_ins_t      ins,
  input  logic                     prev_gt,
  input  logic [skvl_pkg::KEY_W-1:0] prev_key,
  input  logic [skvl_pkg::BAL_W-1:0] prev_bal,
  output logic                     gt,
  output logic [skvl_pkg::KEY_W-1:0] key,
  output logic [skvl_pkg::BAL_W-1:0] bal,
  input  logic                     tok_in_valid,
  input  skvl_pkg::skvl_tok_t      tok_in,
  output logic                     tok_out_valid,
  output skvl_pkg::skvl_tok_t      tok_out
);
  import skvl_pkg::*;

  logic      in_use;
  logic      at_end;
  skvl_tok_t tok_next;

  assign in_use = CW'(IDX) < count;
  assign at_end = CW'(IDX) == count;
  assign gt     = in_use && (key > ins.id);

  // Take the left neighbor on a shift, or the new pair at the insert point
  always_ff @(posedge clk) begin
    if (ins.en) begin
      if (prev_gt) begin
        key <= prev_key;
        bal <= prev_bal;
      end else if (gt || at_end) begin
        key <= ins.id;
        bal <= ins.bal;
      end
    end
  end

  // Resolve the token at the first equal id, first greater id or end of table
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.resolved) begin
      if (!in_use) begin
        tok_next.resolved = 1'b1;
      end else if (key == tok_in.id) begin
        tok_next.resolved = 1'b1;
        tok_next.hit      = 1'b1;
        tok_next.bal      = bal;
      end else if (key > tok_in.id) begin
        tok_next.resolved = 1'b1;
      end
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

@@ design/skvl_checker.sv @@
// Port-level checks of the lookup unit, bound to the top level.
`include "sorted_key_value_lookup_unit_macros.svh"

module skvl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import skvl_pkg::*;

  logic in_xfer;
  logic direct_item;

  assign in_xfer     = s_tvalid && s_tready;
  assign direct_item = in_xfer && (s_tuser != ACT_LOOKUP);

  // A stalled result holds
  `SKVL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Balance and flag stay zero unless an entry was found
  `SKVL_ASSERT_NOW(a_zero_unless_found, m_tvalid && (m_tuser != ST_FOUND),
    m_tdata == 40'd0)

  // Over-limit flag only with a found entry
  `SKVL_ASSERT_NOW(a_over_only_found, m_tvalid && m_tdata[32],
    m_tuser == ST_FOUND)

  // Clear, load and unused items answer in the next cycle with done or full
  `SKVL_ASSERT_NEXT(a_direct_answer, direct_item,
    m_tvalid && ((m_tuser == ST_DONE) || (m_tuser == ST_FULL)))

endmodule

bind sorted_key_value_lookup_unit skvl_checker u_skvl_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the sorted key/value lookup unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skvl_pkg::*;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam logic signed [BAL_W-1:0] BAL_MIN = 32'sh8000_0000;
  localparam logic signed [BAL_W-1:0] BAL_MAX = 32'sh7fff_ffff;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 31'h7fff_ffff;

  // One answer of the lookup unit, as the checker compares it
  typedef struct packed {
    logic [1:0]              status;
    logic signed [BAL_W-1:0] bal;
    logic                    over;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // cust_id [15:0], balance_in [47:16]
  logic [1:0]  s_tuser = ACT_CLEAR;  // action [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [39:0] m_tdata;         // balance_out [31:0], over_limit [32], zero [39:33]
  logic [1:0]  m_tuser;         // status [1:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;   // credit_limit [30:0]

  // Shadow table kept in ascending id order
  logic [KEY_W-1:0]        shadow_key [DEPTH];
  logic signed [BAL_W-1:0] shadow_bal [DEPTH];
  int                      shadow_count = 0;
  logic [LIMIT_W-1:0]      shadow_limit = LIMIT_RESET;

  lookup_result_t expected_q [$];
  bit idle_on = 1'b1;
  int err_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int n_items = 0, n_loads = 0, n_full = 0, n_lookups = 0, n_hits = 0;
  int n_over = 0, n_clears = 0, n_unused = 0, n_limit_writes = 0;

  sorted_key_value_lookup_unit #(.TABLE_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Apply one accepted item to the shadow table and return its answer
  function automatic lookup_result_t apply_item(logic [1:0] act, logic [KEY_W-1:0] id,
                                                logic signed [BAL_W-1:0] bal);
    lookup_result_t r;
    int pos;
    bit done;
    r.status = ST_DONE;
    r.bal = '0;
    r.over = 1'b0;
    n_items++;
    case (act)
      ACT_CLEAR: begin
        shadow_count = 0;
        n_clears++;
      end
      ACT_LOAD: begin
        n_loads++;
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // insert behind equal ids, in front of the first greater one
          pos = shadow_count;
          for (int i = 0; i < shadow_count; i++)
            if (pos == shadow_count && shadow_key[i] > id) pos = i;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_bal[i] = shadow_bal[i-1];
          end
          shadow_key[pos] = id;
          shadow_bal[pos] = bal;
          shadow_count++;
        end
      end
      ACT_LOOKUP: begin
        n_lookups++;
        r.status = ST_MISS;
        done = 1'b0;
        // scan ascending, stop on the first equal or greater id
        for (int i = 0; i < shadow_count; i++) begin
          if (!done && shadow_key[i] == id) begin
            r.status = ST_FOUND;
            r.bal = shadow_bal[i];
            r.over = longint'(shadow_bal[i]) > longint'(shadow_limit);
            done = 1'b1;
          end else if (!done && shadow_key[i] > id) begin
            done = 1'b1;
          end
        end
        if (r.status == ST_FOUND) n_hits++;
        if (r.over) n_over++;
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // Drive one item, hold it until the transfer, then record its answer
  task automatic send_item(input logic [1:0] act, input logic [KEY_W-1:0] id,
                           input logic signed [BAL_W-1:0] bal);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {bal, id};
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(apply_item(act, id, bal));
  endtask

  // Stop sending and wait until the unit has answered everything
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 2) @(posedge clk);
  endtask

  // Write the credit limit; call only while the unit is idle
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_limit = value;
    n_limit_writes++;
  endtask

  // Empty table, unused action code, id and balance extremes, duplicates
  task automatic test_basics();
    send_item(ACT_LOOKUP, 16'd7, 32'sd0);
    send_item(2'd3, 16'hffff, BAL_MAX);
    send_item(ACT_LOAD, 16'd0, BAL_MIN);
    send_item(ACT_LOAD, 16'hffff, BAL_MAX);
    send_item(ACT_LOAD, 16'd500, 32'sd10000);
    send_item(ACT_LOAD, 16'd500, 32'sd10001);
    send_item(ACT_LOAD, 16'd300, 32'sd0);
    send_item(ACT_LOOKUP, 16'd0, 32'sd0);
    send_item(ACT_LOOKUP, 16'hffff, 32'sd0);
    send_item(ACT_LOOKUP, 16'd500, 32'sd0);
    send_item(ACT_LOOKUP, 16'd400, 32'sd0);
    send_item(ACT_CLEAR, 16'd500, BAL_MIN);
    send_item(ACT_LOOKUP, 16'd500, 32'sd0);
  endtask

  // Fill front-first with descending ids, then one load too many
  task automatic test_full_table();
    for (int i = DEPTH; i >= 1; i--)
      send_item(ACT_LOAD, 16'(i * 100), 32'(i * 1000 - 8000));
    send_item(ACT_LOAD, 16'd50, 32'sd1);
    send_item(ACT_LOOKUP, 16'd100, 32'sd0);
    send_item(ACT_LOOKUP, 16'(DEPTH * 100), 32'sd0);
  endtask

  // Lowest and highest credit limit against known balances
  task automatic test_limit_extremes();
    drain();
    write_limit('0);
    send_item(ACT_LOOKUP, 16'd800, 32'sd0);
    send_item(ACT_LOOKUP, 16'd900, 32'sd0);
    send_item(ACT_LOOKUP, 16'd700, 32'sd0);
    drain();
    write_limit(LIMIT_MAX);
    send_item(ACT_CLEAR, 16'd0, 32'sd0);
    send_item(ACT_LOAD, 16'd9, BAL_MAX);
    send_item(ACT_LOOKUP, 16'd9, 32'sd0);
  endtask

  // Random loads and lookups over a narrow id pool, with clears and noise
  task automatic test_random(input int count, input logic [LIMIT_W-1:0] limit,
                             input bit with_idle);
    int pick;
    int key_base;
    logic [1:0] act;
    logic [KEY_W-1:0] id;
    logic signed [BAL_W-1:0] bal;
    logic [BAL_W-1:0] lim32;
    drain();
    write_limit(limit);
    idle_on = with_idle;
    key_base = $urandom_range(0, 65535 - 24);
    lim32 = {1'b0, limit};
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      id = 16'($urandom());
      bal = 32'($urandom());
      if (pick < 3) begin
        act = ACT_CLEAR;
      end else if (pick < 7) begin
        act = 2'd3;
      end else if (pick < 46) begin
        act = ACT_LOAD;
        if ($urandom_range(0, 4) != 0) id = 16'(key_base + $urandom_range(0, 23));
        case ($urandom_range(0, 5))
          0: bal = lim32 - 1;
          1: bal = lim32;
          2: bal = lim32 + 1;
          3: bal = 32'($signed($urandom_range(0, 40000)) - 20000);
          default: ;
        endcase
      end else begin
        act = ACT_LOOKUP;
        pick = $urandom_range(0, 9);
        if (pick < 5 && shadow_count > 0)
          id = shadow_key[$urandom_range(0, shadow_count - 1)];
        else if (pick < 8)
          id = 16'(key_base + $urandom_range(0, 24));
      end
      send_item(act, id, bal);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basics();
    test_full_table();
    test_limit_extremes();
    test_random(300, 31'($urandom()), 1'b1);
    test_random(300, 31'($urandom_range(0, 50000)), 1'b1);
    test_random(300, LIMIT_RESET, 1'b1);
    test_random(300, 31'($urandom_range(0, 20000)), 1'b0);
    drain();
    $display("covered %0d items: %0d loads (%0d refused, table full), %0d clears",
             n_items, n_loads, n_full, n_clears);
    $display("%0d lookups (%0d hits, %0d above limit), %0d unused codes, %0d limit writes",
             n_lookups, n_hits, n_over, n_unused, n_limit_writes);
    if (err_count == 0)
      $display("[sorted_key_value_lookup_unit] OK");
    else
      $display("[sorted_key_value_lookup_unit] ERROR");
    $finish;
  end

  // Stall the result side in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected answer
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with no expected answer: status %0d", m_tuser);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          err_count++;
        end
        if (m_tdata[31:0] !== want.bal) begin
          $error("balance_out: expected %0d, got %0d", want.bal, $signed(m_tdata[31:0]));
          err_count++;
        end
        if (m_tdata[32] !== want.over) begin
          $error("over_limit: expected %0d, got %0d", want.over, m_tdata[32]);
          err_count++;
        end
        if (m_tdata[39:33] !== 7'd0) begin
          $error("tdata padding: expected 0, got %0h", m_tdata[39:33]);
          err_count++;
        end
      end
    end
  end

  // Abort when no transfer happens on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("[sorted_key_value_lookup_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ sorted_key_value_lookup_unit.f @@
+incdir+design
design/skvl_pkg.sv
design/skvl_cell.sv
design/sorted_key_value_lookup_unit.sv
design/skvl_checker.sv
sim/tb.sv
